// File: src/enfa_pkg.sv
package enfa_pkg;

   localparam int SET_W = 16;
   localparam int SYM_W = 8;
   localparam int STATE_ID_W = 4;
   localparam int INDEX_W = 6;
   localparam int INDEX_SPAN = 1 << INDEX_W;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [SET_W-1:0] START_SET_RESET = 16'h0001;
   localparam logic [SET_W-1:0] ACCEPT_SET_RESET = 16'h0000;
   localparam logic [SYM_W-1:0] EPS_SYMBOL_RESET = 8'd42;

   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_CONSUME = 2'd1,
      ACT_FINISH  = 2'd2,
      ACT_NOP     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_START_SET  = 2'd0,
      REG_ACCEPT_SET = 2'd1,
      REG_EPS_SYMBOL = 2'd2,
      REG_UNUSED     = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLOSE_PRE,
      ST_MOVE,
      ST_CLOSE_POST
   } state_type;

   typedef struct packed {
      logic start;
      logic write_entry;
      logic grow;
      logic move;
      logic emit;
      logic restart;
   } cmd_type;

   typedef struct packed {
      logic stable;
      logic out_free;
   } status_type;

endpackage

// File: src/enfa_ctrl.sv
module enfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_action,
   input  enfa_pkg::status_type status,
   output enfa_pkg::cmd_type    cmd
);
   import enfa_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   logic [1:0] action_ff;
   logic [1:0] action_in;
   logic       final_pass;

   // The closure before the move is the last one except for a consume.
   assign final_pass = (state_ff == ST_CLOSE_POST) || (action_ff != ACT_CONSUME);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         action_ff <= ACT_NOP;
      end else begin
         state_ff  <= state_in;
         action_ff <= action_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      action_in = action_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in  = ST_CLOSE_PRE;
               action_in = req_action;
            end
         end
         ST_CLOSE_PRE: begin
            if (status.stable) begin
               if (action_ff == ACT_CONSUME) begin
                  state_in = ST_MOVE;
               end else if (status.out_free) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MOVE: begin
            state_in = ST_CLOSE_POST;
         end
         ST_CLOSE_POST: begin
            if (status.stable && status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.start       = req_valid;
            cmd.write_entry = req_valid && (req_action == ACT_LOAD);
         end
         ST_CLOSE_PRE, ST_CLOSE_POST: begin
            cmd.grow = 1'b1;
            if (status.stable && final_pass && status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.restart = (action_ff == ACT_FINISH);
            end
         end
         ST_MOVE: begin
            cmd.move = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: src/enfa_dp.sv
module enfa_dp #(
   parameter int NUM_STATES  = 16,
   parameter int NUM_ENTRIES = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  enfa_pkg::cmd_type                     cmd,
   output enfa_pkg::status_type                  status,
   input  logic [enfa_pkg::INDEX_W-1:0]          req_entry_index,
   input  logic                                  req_entry_valid,
   input  logic [enfa_pkg::STATE_ID_W-1:0]       req_from_state,
   input  logic [enfa_pkg::STATE_ID_W-1:0]       req_to_state,
   input  logic [enfa_pkg::SYM_W-1:0]            req_symbol,
   input  logic [enfa_pkg::SET_W-1:0]            start_set,
   input  logic [enfa_pkg::SET_W-1:0]            accept_set,
   input  logic [enfa_pkg::SYM_W-1:0]            eps_symbol,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_accepted,
   output logic [enfa_pkg::SET_W-1:0]            rsp_active_set
);
   import enfa_pkg::*;

   localparam logic [SET_W-1:0] SET_MASK = (NUM_STATES >= SET_W) ? {SET_W{1'b1}} :
                                           SET_W'((32'd1 << NUM_STATES) - 32'd1);

   logic                  ent_valid_ff [NUM_ENTRIES];
   logic [STATE_ID_W-1:0] ent_from_ff  [NUM_ENTRIES];
   logic [STATE_ID_W-1:0] ent_to_ff    [NUM_ENTRIES];
   logic [SYM_W-1:0]      ent_sym_ff   [NUM_ENTRIES];
   logic [SET_W-1:0]      contrib      [NUM_ENTRIES];

   logic [SET_W-1:0] current_ff;
   logic [SET_W-1:0] current_in;
   logic [SET_W-1:0] work_ff;
   logic [SET_W-1:0] work_in;
   logic [SYM_W-1:0] sym_ff;
   logic [SYM_W-1:0] sym_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             accepted_ff;
   logic             accepted_in;
   logic [SET_W-1:0] active_ff;
   logic [SET_W-1:0] active_in;

   logic [SYM_W-1:0] step_sym;
   logic [SET_W-1:0] step_set;
   logic [SET_W-1:0] grown_set;

   // The move step follows the consumed symbol; every other step is epsilon.
   assign step_sym = cmd.move ? sym_ff : eps_symbol;

   for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_entry
      logic sel;
      logic in_range;

      if (i < INDEX_SPAN) begin : g_addr
         assign sel = cmd.write_entry && (req_entry_index == INDEX_W'(i));
      end else begin : g_noaddr
         assign sel = 1'b0;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ent_valid_ff[i] <= 1'b0;
         end else if (sel) begin
            ent_valid_ff[i] <= req_entry_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (sel) begin
            ent_from_ff[i] <= req_from_state;
            ent_to_ff[i]   <= req_to_state;
            ent_sym_ff[i]  <= req_symbol;
         end
      end

      // Transitions naming a state past the configured count never fire.
      assign in_range = (32'(ent_from_ff[i]) < 32'(NUM_STATES)) &&
                        (32'(ent_to_ff[i]) < 32'(NUM_STATES));

      assign contrib[i] = (ent_valid_ff[i] && in_range && (ent_sym_ff[i] == step_sym) &&
                           work_ff[ent_from_ff[i]]) ?
                          (SET_W'(1) << ent_to_ff[i]) : '0;
   end

   always_comb begin
      step_set = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         step_set = step_set | contrib[i];
      end
      step_set = step_set & SET_MASK;
   end

   assign grown_set = work_ff | step_set;

   assign status.stable   = (grown_set == work_ff);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      current_in   = current_ff;
      work_in      = work_ff;
      sym_in       = sym_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      accepted_in  = accepted_ff;
      active_in    = active_ff;
      if (cmd.start) begin
         work_in = current_ff & SET_MASK;
         sym_in  = req_symbol;
      end
      if (cmd.grow) begin
         work_in = grown_set;
      end
      if (cmd.move) begin
         work_in    = step_set;
         current_in = step_set;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         accepted_in  = |(work_ff & accept_set);
         if (cmd.restart) begin
            current_in = start_set & SET_MASK;
            active_in  = start_set & SET_MASK;
         end else begin
            active_in = current_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff   <= START_SET_RESET & SET_MASK;
         rsp_valid_ff <= 1'b0;
      end else begin
         current_ff   <= current_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      sym_ff      <= sym_in;
      accepted_ff <= accepted_in;
      active_ff   <= active_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = accepted_ff;
   assign rsp_active_set = active_ff;

endmodule

// File: src/epsilon_nfa_matcher_top.sv
// A transaction is taken in the idle state. Each epsilon closure then grows the set pass by pass
// over the whole table until a pass adds nothing.
// A consume runs two closures around a move; other transactions run one closure. A result is
// emitted only once the output register is free. One transaction is processed at a time;
// the next one is taken while a result waits in the output register.
// Synchronous active-high reset invalidates the table, restores the registers and the set.
module epsilon_nfa_matcher_top #(
   parameter int NUM_STATES  = 16,
   parameter int NUM_ENTRIES = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_action,
   input  logic [enfa_pkg::INDEX_W-1:0]          req_entry_index,
   input  logic                                  req_entry_valid,
   input  logic [enfa_pkg::STATE_ID_W-1:0]       req_from_state,
   input  logic [enfa_pkg::STATE_ID_W-1:0]       req_to_state,
   input  logic [enfa_pkg::SYM_W-1:0]            req_symbol,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_accepted,
   output logic [enfa_pkg::SET_W-1:0]            rsp_active_set,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [enfa_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [enfa_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [enfa_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import enfa_pkg::*;

   logic [SET_W-1:0] start_set_ff;
   logic [SET_W-1:0] start_set_in;
   logic [SET_W-1:0] accept_set_ff;
   logic [SET_W-1:0] accept_set_in;
   logic [SYM_W-1:0] eps_symbol_ff;
   logic [SYM_W-1:0] eps_symbol_in;
   logic             csr_write;
   reg_index_type    csr_index;

   cmd_type    cmd;
   status_type status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      start_set_in  = start_set_ff;
      accept_set_in = accept_set_ff;
      eps_symbol_in = eps_symbol_ff;
      if (csr_write) begin
         case (csr_index)
            REG_START_SET:  start_set_in  = csr_pwdata[SET_W-1:0];
            REG_ACCEPT_SET: accept_set_in = csr_pwdata[SET_W-1:0];
            REG_EPS_SYMBOL: eps_symbol_in = csr_pwdata[SYM_W-1:0];
            default: begin
               start_set_in = start_set_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_set_ff  <= START_SET_RESET;
         accept_set_ff <= ACCEPT_SET_RESET;
         eps_symbol_ff <= EPS_SYMBOL_RESET;
      end else begin
         start_set_ff  <= start_set_in;
         accept_set_ff <= accept_set_in;
         eps_symbol_ff <= eps_symbol_in;
      end
   end

   always_comb begin
      case (csr_index)
         REG_START_SET:  csr_prdata = CSR_DATA_W'(start_set_ff);
         REG_ACCEPT_SET: csr_prdata = CSR_DATA_W'(accept_set_ff);
         REG_EPS_SYMBOL: csr_prdata = CSR_DATA_W'(eps_symbol_ff);
         default:        csr_prdata = '0;
      endcase
   end

   enfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd)
   );

   enfa_dp #(
      .NUM_STATES  (NUM_STATES),
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_entry_index (req_entry_index),
      .req_entry_valid (req_entry_valid),
      .req_from_state  (req_from_state),
      .req_to_state    (req_to_state),
      .req_symbol      (req_symbol),
      .start_set       (start_set_ff),
      .accept_set      (accept_set_ff),
      .eps_symbol      (eps_symbol_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_accepted    (rsp_accepted),
      .rsp_active_set  (rsp_active_set)
   );

endmodule

// File: test/epsilon_nfa_matcher_top_test.sv
`timescale 1ns / 1ps

module epsilon_nfa_matcher_top_test;
   import enfa_pkg::*;

   localparam int LONG_HOLD = 120;
   localparam int SETTLE_CYCLES = 2 * SET_W + 8;

   typedef struct packed {
      logic                  used;
      logic [STATE_ID_W-1:0] src;
      logic [STATE_ID_W-1:0] dst;
      logic [SYM_W-1:0]      code;
   } arc_entry_type;

   typedef struct {
      action_type            act;
      logic [INDEX_W-1:0]    slot;
      logic                  used;
      logic [STATE_ID_W-1:0] src;
      logic [STATE_ID_W-1:0] dst;
      logic [SYM_W-1:0]      code;
   } nfa_op_type;

   typedef struct {
      logic             accepted;
      logic [SET_W-1:0] active;
   } nfa_verdict_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_action = ACT_NOP;
   logic [INDEX_W-1:0]    req_entry_index = '0;
   logic                  req_entry_valid = 1'b0;
   logic [STATE_ID_W-1:0] req_from_state = '0;
   logic [STATE_ID_W-1:0] req_to_state = '0;
   logic [SYM_W-1:0]      req_symbol = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_accepted;
   logic [SET_W-1:0]      rsp_active_set;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Shadow of the matcher: transition table, active set and registers.
   arc_entry_type    arc_table [INDEX_SPAN];
   logic [SET_W-1:0] nfa_active;
   logic [SET_W-1:0] cfg_start;
   logic [SET_W-1:0] cfg_accept;
   logic [SYM_W-1:0] cfg_eps;
   logic [SYM_W-1:0] alphabet [4];

   nfa_op_type      pending_ops [$];
   nfa_verdict_type verdict_queue [$];
   nfa_op_type      offered;

   int idle_odds = 4;
   int hold_orders = 0;
   int hold_taken = 0;
   int hold_left = 0;
   int send_gap = 0;
   int take_gap = 0;
   int mismatches = 0;

   epsilon_nfa_matcher_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_entry_index(req_entry_index),
      .req_entry_valid(req_entry_valid),
      .req_from_state(req_from_state),
      .req_to_state(req_to_state),
      .req_symbol(req_symbol),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_accepted(rsp_accepted),
      .rsp_active_set(rsp_active_set),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   // States reached in one step from from_set over valid entries carrying code.
   function automatic logic [SET_W-1:0] fire_on(input logic [SET_W-1:0] from_set,
                                                 input logic [SYM_W-1:0] code);
      logic [SET_W-1:0] reached;
      arc_entry_type    arc;
      reached = '0;
      for (int i = 0; i < INDEX_SPAN; i++) begin
         arc = arc_table[INDEX_W'(i)];
         if (arc.used && arc.code == code && from_set[arc.src])
            reached[arc.dst] = 1'b1;
      end
      return reached;
   endfunction

   function automatic logic [SET_W-1:0] eps_reach(input logic [SET_W-1:0] seed);
      logic [SET_W-1:0] grown;
      for (int pass = 0; pass <= SET_W; pass++) begin
         grown = seed | fire_on(seed, cfg_eps);
         if (grown == seed)
            break;
         seed = grown;
      end
      return seed;
   endfunction

   function automatic nfa_verdict_type advance_nfa(input nfa_op_type op);
      nfa_verdict_type verdict;
      case (op.act)
         ACT_LOAD: begin
            arc_table[op.slot] = '{op.used, op.src, op.dst, op.code};
         end
         ACT_CONSUME: begin
            nfa_active = fire_on(eps_reach(nfa_active), op.code);
         end
         default: begin
         end
      endcase
      // A finish judges the set it ends, then restarts from the start mask.
      verdict.accepted = |(eps_reach(nfa_active) & cfg_accept);
      if (op.act == ACT_FINISH)
         nfa_active = cfg_start;
      verdict.active = nfa_active;
      return verdict;
   endfunction

   function automatic nfa_op_type random_op();
      nfa_op_type op;
      int pick;
      op.act = ACT_NOP;
      op.slot = INDEX_W'($urandom_range(0, INDEX_SPAN - 1));
      op.used = 1'($urandom_range(0, 1));
      op.src = STATE_ID_W'($urandom_range(0, 15));
      op.dst = STATE_ID_W'($urandom_range(0, 15));
      op.code = SYM_W'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         op.act = ACT_LOAD;
         // Reuse a few low slots so that entries get overwritten and disabled.
         if ($urandom_range(0, 9) < 7)
            op.slot = INDEX_W'($urandom_range(0, 15));
         op.used = ($urandom_range(0, 9) != 0);
         if ($urandom_range(0, 9) < 8)
            op.code = alphabet[2'($urandom_range(0, 3))];
      end else if (pick < 82) begin
         op.act = ACT_CONSUME;
         if ($urandom_range(0, 9) < 9)
            op.code = alphabet[2'($urandom_range(0, 3))];
      end else if (pick < 96) begin
         op.act = ACT_FINISH;
      end
      return op;
   endfunction

   task automatic push_op(input action_type act, input int slot, input logic used,
                          input int src, input int dst, input int code);
      nfa_op_type op;
      op.act = act;
      op.slot = INDEX_W'(slot);
      op.used = used;
      op.src = STATE_ID_W'(src);
      op.dst = STATE_ID_W'(dst);
      op.code = SYM_W'(code);
      pending_ops.insert(pending_ops.size(), op);
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++)
         pending_ops.insert(pending_ops.size(), random_op());
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_ops.size() != 0 || req_valid || verdict_queue.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(input reg_index_type which, input logic [CSR_DATA_W-1:0] word);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {which, 2'b00};
      csr_pwdata <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      case (which)
         REG_START_SET:  cfg_start = word[SET_W-1:0];
         REG_ACCEPT_SET: cfg_accept = word[SET_W-1:0];
         REG_EPS_SYMBOL: cfg_eps = word[SYM_W-1:0];
         default: begin
         end
      endcase
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Upper bits of the write data carry noise that the registers must drop.
   task automatic configure(input logic [SET_W-1:0] start, input logic [SET_W-1:0] accept,
                            input logic [SYM_W-1:0] eps);
      logic [15:0] noise;
      noise = 16'($urandom);
      csr_write(REG_START_SET, {noise, start});
      csr_write(REG_ACCEPT_SET, {noise, accept});
      csr_write(REG_EPS_SYMBOL, {noise, 8'(noise), eps});
      alphabet[0] = eps;
      for (int i = 1; i < 4; i++)
         alphabet[i] = SYM_W'($urandom_range(0, 255));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            verdict_queue.insert(verdict_queue.size(), advance_nfa(offered));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() > 0 && idle_odds != 0
                         && $urandom_range(0, idle_odds - 1) == 0) begin
               send_gap = $urandom_range(0, 12);
               req_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               offered = pending_ops.pop_front();
               req_valid <= 1'b1;
               req_action <= offered.act;
               req_entry_index <= offered.slot;
               req_entry_valid <= offered.used;
               req_from_state <= offered.src;
               req_to_state <= offered.dst;
               req_symbol <= offered.code;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_queue.size() == 0) begin
               $display("%0t: transaction expected none actual accepted=%0b active_set=%h",
                        $time, rsp_accepted, rsp_active_set);
               mismatches++;
            end else begin
               nfa_verdict_type want;
               want = verdict_queue.pop_front();
               if (rsp_accepted !== want.accepted) begin
                  $display("%0t: accepted expected %0b actual %0b",
                           $time, want.accepted, rsp_accepted);
                  mismatches++;
               end
               if (rsp_active_set !== want.active) begin
                  $display("%0t: active_set expected %h actual %h",
                           $time, want.active, rsp_active_set);
                  mismatches++;
               end
            end
         end
         if (hold_orders != hold_taken) begin
            hold_taken = hold_orders;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_ready <= 1'b0;
         end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
            take_gap = $urandom_range(0, 12);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("epsilon_nfa_matcher_top test failed");
      $finish;
   end

   initial begin
      for (int i = 0; i < INDEX_SPAN; i++)
         arc_table[INDEX_W'(i)] = '0;
      cfg_start = START_SET_RESET;
      cfg_accept = ACCEPT_SET_RESET;
      cfg_eps = EPS_SYMBOL_RESET;
      nfa_active = START_SET_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset registers: empty string, empty table, unused action, low entries and the last slot.
      push_op(ACT_FINISH, 0, 1'b0, 0, 0, 0);
      push_op(ACT_CONSUME, 0, 1'b0, 0, 0, 8'h61);
      push_op(ACT_NOP, 63, 1'b1, 15, 15, 255);
      push_op(ACT_FINISH, 0, 1'b0, 0, 0, 0);
      push_op(ACT_LOAD, 0, 1'b1, 0, 1, 42);
      push_op(ACT_LOAD, 63, 1'b1, 1, 2, 8'h61);
      push_op(ACT_LOAD, 1, 1'b1, 2, 15, 42);
      push_op(ACT_LOAD, 2, 1'b1, 15, 3, 255);
      push_op(ACT_LOAD, 3, 1'b0, 15, 0, 0);
      wait_drained();

      csr_write(REG_ACCEPT_SET, 32'h0000_8004);
      push_op(ACT_LOAD, 4, 1'b1, 3, 3, 42);
      push_op(ACT_CONSUME, 0, 1'b0, 0, 0, 8'h61);
      push_op(ACT_CONSUME, 0, 1'b0, 0, 0, 255);
      // Consuming the epsilon code follows the epsilon entries.
      push_op(ACT_CONSUME, 0, 1'b0, 0, 0, 42);
      push_op(ACT_FINISH, 0, 1'b0, 0, 0, 0);
      push_op(ACT_FINISH, 0, 1'b0, 0, 0, 0);
      push_op(ACT_LOAD, 63, 1'b1, 15, 15, 255);
      push_op(ACT_LOAD, 1, 1'b0, 2, 15, 42);
      push_op(ACT_CONSUME, 0, 1'b0, 0, 0, 8'h61);
      push_op(ACT_CONSUME, 63, 1'b1, 15, 15, 0);
      wait_drained();

      // The new start mask must not apply until the next finish.
      csr_write(REG_EPS_SYMBOL, 32'h0000_0000);
      csr_write(REG_START_SET, 32'h0000_FFFF);
      push_op(ACT_CONSUME, 0, 1'b0, 0, 0, 0);
      push_op(ACT_LOAD, 5, 1'b1, 0, 7, 0);
      push_op(ACT_FINISH, 0, 1'b0, 0, 0, 0);
      push_op(ACT_CONSUME, 0, 1'b0, 0, 0, 42);
      push_op(ACT_FINISH, 0, 1'b0, 0, 0, 0);
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: configure(16'h0001, 16'h8000, 8'd42);
            1: configure(16'hFFFF, 16'hFFFF, 8'd255);
            2: configure(16'h0000, 16'h0000, 8'd0);
            default: configure(($urandom_range(0, 1) != 0) ? 16'(1 << $urandom_range(0, 15))
                                                          : 16'($urandom),
                               16'($urandom), 8'($urandom_range(0, 255)));
         endcase
         case (phase)
            0: idle_odds <= 4;
            1: idle_odds <= 3;
            3: idle_odds <= 2;
            4: idle_odds <= 6;
            default: idle_odds <= 0;
         endcase
         if (phase == 1) begin
            // The sender keeps offering while the receiver holds off, so the block backs up.
            queue_random(75);
            hold_orders <= hold_orders + 1;
         end else if (phase == 3) begin
            queue_random(35);
            wait_drained();
            queue_random(40);
         end else begin
            queue_random(75);
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && verdict_queue.size() == 0) begin
         $display("epsilon_nfa_matcher_top test passed");
      end else begin
         $display("epsilon_nfa_matcher_top test failed");
      end
      $finish;
   end

endmodule
